// ===== sv/bprs_pkg.sv =====
// bprs_pkg: shared constants, register codes and cosine table maths for the
// bpsk ranging signal generator. No dependencies.
`default_nettype none

package bprs_pkg;

  // default sizes handed to the top level
  localparam int unsigned CODE_LENGTH_DEF    = 2046;
  localparam int unsigned COS_TABLE_BITS_DEF = 10;
  localparam int unsigned SAMPLE_BITS_DEF    = 16;

  // fixed point layout of the code phase and step
  localparam int unsigned CODE_FRAC_BITS   = 21;
  localparam int unsigned STEP_ALIGN_SHIFT = 9;
  localparam int unsigned STEP_W           = 32 - STEP_ALIGN_SHIFT;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PRN_W      = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRN_NUMBER   = 2'd0,
    REG_CARRIER_STEP = 2'd1,
    REG_CODE_STEP    = 2'd2,
    REG_CODE_START   = 2'd3
  } cfg_reg_e;

  // register reset values
  localparam logic [PRN_W-1:0]      PRN_RESET        = 6'd1;
  localparam logic [CFG_DATA_W-1:0] CARRIER_STEP_RST = 32'd0;
  localparam logic [CFG_DATA_W-1:0] CODE_STEP_RST    = 32'd844952220;

  // output queue between the pipeline and the receiver
  localparam int unsigned FIFO_DEPTH = 4;

  // q30 constants for the cosine series
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // cosine magnitude for quarter-wave entry k, scaled to 2^(sb-1)-1
  // evaluated at elaboration only, taylor series to x^12 in truncated q30
  function automatic int unsigned cos_mag(int unsigned k, int unsigned tb,
                                          int unsigned sb);
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] x;
    logic [63:0] prod;
    logic [63:0] t;
    logic [63:0] scale;
    r = 64'(k) << (32 - tb);
    a = (r * HALF_PI_Q30) >> 30;
    a2 = (a * a) >> 30;
    x = Q30_ONE;
    for (int i = 0; i < 6; i++) begin
      prod = (a2 * x) >> 30;
      case (i)
        0:       t = prod / 64'd132;
        1:       t = prod / 64'd90;
        2:       t = prod / 64'd56;
        3:       t = prod / 64'd30;
        4:       t = prod / 64'd12;
        default: t = prod / 64'd2;
      endcase
      x = (t >= Q30_ONE) ? 64'd0 : (Q30_ONE - t);
    end
    scale = (64'd1 << (sb - 1)) - 64'd1;
    return 32'((x * scale + (64'd1 << 29)) >> 30);
  endfunction

endpackage

`default_nettype wire

// ===== sv/bprs_cos_rom.sv =====
// bprs_cos_rom: quarter-wave cosine magnitude rom with registered read.
// Contents are built at elaboration from bprs_pkg::cos_mag.
`default_nettype none

module bprs_cos_rom #(
  parameter int unsigned COS_TABLE_BITS = bprs_pkg::COS_TABLE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS    = bprs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic [COS_TABLE_BITS-2:0] addr_i,
  output logic      [SAMPLE_BITS-2:0]    mag_o
);

  localparam int unsigned Depth = (1 << (COS_TABLE_BITS - 2)) + 1;
  localparam int unsigned MagW  = SAMPLE_BITS - 1;

  typedef logic [MagW-1:0] rom_t [Depth];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k < Depth; k++) begin
      rom[k] = MagW'(bprs_pkg::cos_mag(k, COS_TABLE_BITS, SAMPLE_BITS));
    end
    return rom;
  endfunction

  localparam rom_t Rom = build_rom();

  logic [MagW-1:0] mag_q;

  // registered table read
  always_ff @(posedge clk_i) begin
    mag_q <= Rom[addr_i];
  end

  assign mag_o = mag_q;

endmodule

`default_nettype wire

// ===== sv/bprs_out_fifo.sv =====
// bprs_out_fifo: small result queue that decouples the sample pipeline from
// the receiver stall. Depends on bprs_pkg for its default width and depth.
`default_nettype none

module bprs_out_fifo #(
  parameter int unsigned WIDTH = bprs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned DEPTH = bprs_pkg::FIFO_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           data_i,
  input  wire logic                       pop_i,
  output logic                            valid_o,
  output logic      [WIDTH-1:0]           data_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== sv/bpsk_ranging_signal_generator_top.sv =====
// bpsk_ranging_signal_generator_top: carrier and code phase accumulators,
// chip sign, cosine lookup and result queue. Uses bprs_pkg, bprs_cos_rom
// and bprs_out_fifo.
//
// Usage:
//   Each request on the input channel (in_valid_i high, in_stall_o low) carries
//   one restart flag and yields exactly one signed sample on the output channel
//   (out_valid_o high, out_stall_i low). restart_i = 1 makes that sample sample
//   zero: carrier phase 0, code phase code_start reduced modulo the code length.
//   Throughput is one sample per clock while in_stall_o is low; the next phases
//   are formed combinationally from the current ones. out_valid_o rises once an
//   accepted request has passed the table phase register, the table read
//   register and then the queue. Configuration is written through cfg_we_i /
//   cfg_idx_i / cfg_data_i while no request is in flight; code_start is reduced
//   as it is written. Reset clears both phase accumulators to zero, loads the
//   register defaults and empties the result queue. When the receiver stalls,
//   finished samples wait in a four-entry queue; in_stall_o rises once queue and
//   pipeline together hold four samples, and it depends on registers only.
`default_nettype none

module bpsk_ranging_signal_generator_top #(
  parameter int unsigned CODE_LENGTH    = bprs_pkg::CODE_LENGTH_DEF,
  parameter int unsigned COS_TABLE_BITS = bprs_pkg::COS_TABLE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS    = bprs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                restart_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]            i_sample_o,
  // configuration port
  input  wire logic                                cfg_we_i,
  input  wire logic [bprs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [bprs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned FracW   = bprs_pkg::CODE_FRAC_BITS;
  localparam int unsigned ChipW   = $clog2(CODE_LENGTH);
  localparam int unsigned CodeW   = ChipW + FracW;
  localparam int unsigned SumW    = CodeW + 2;
  localparam int unsigned AddrW   = COS_TABLE_BITS - 1;
  localparam int unsigned FoldW   = COS_TABLE_BITS - 2;
  localparam int unsigned MagW    = SAMPLE_BITS - 1;
  localparam int unsigned Depth   = bprs_pkg::FIFO_DEPTH;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned HiW     = bprs_pkg::CFG_DATA_W - FracW;
  localparam logic [SumW-1:0]  Limit   = SumW'(CODE_LENGTH) << FracW;
  localparam logic [AddrW-1:0] Quarter = AddrW'(1) << FoldW;

  // chip count of a written code start, reduced modulo the code length
  function automatic logic [ChipW-1:0] reduce_chips(logic [HiW-1:0] hi);
    int unsigned rem;
    rem = int'(hi);
    for (int k = HiW - 1; k >= 0; k--) begin
      if (((CODE_LENGTH << k) < (1 << HiW)) && (rem >= (CODE_LENGTH << k))) begin
        rem = rem - (CODE_LENGTH << k);
      end
    end
    return ChipW'(rem);
  endfunction

  // configuration registers
  logic [bprs_pkg::PRN_W-1:0]      prn_q;
  logic [bprs_pkg::CFG_DATA_W-1:0] carrier_step_q;
  logic [bprs_pkg::CFG_DATA_W-1:0] code_step_q;
  logic [CodeW-1:0]                code_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prn_q          <= bprs_pkg::PRN_RESET;
      carrier_step_q <= bprs_pkg::CARRIER_STEP_RST;
      code_step_q    <= bprs_pkg::CODE_STEP_RST;
      code_start_q   <= '0;
    end else if (cfg_we_i) begin
      case (bprs_pkg::cfg_reg_e'(cfg_idx_i))
        bprs_pkg::REG_PRN_NUMBER:   prn_q <= cfg_data_i[bprs_pkg::PRN_W-1:0];
        bprs_pkg::REG_CARRIER_STEP: carrier_step_q <= cfg_data_i;
        bprs_pkg::REG_CODE_STEP:    code_step_q <= cfg_data_i;
        bprs_pkg::REG_CODE_START: begin
          code_start_q <= {reduce_chips(cfg_data_i[bprs_pkg::CFG_DATA_W-1:FracW]),
                           cfg_data_i[FracW-1:0]};
        end
        default: ;
      endcase
    end
  end

  // request acceptance and back-pressure from queue occupancy
  logic            accept;
  logic            v1_q, v2_q;
  logic [CntW-1:0] fifo_count;
  logic [CntW:0]   occupancy;

  assign occupancy  = (CntW + 1)'(fifo_count) + (CntW + 1)'(v1_q) + (CntW + 1)'(v2_q);
  assign in_stall_o = (occupancy >= (CntW + 1)'(Depth));
  assign accept     = in_valid_i && !in_stall_o;

  // phase accumulators
  logic [31:0]      carrier_acc_q, carrier_acc_d, carrier_cur;
  logic [CodeW-1:0] code_acc_q, code_acc_d, code_cur;
  logic [SumW-1:0]  code_sum, code_red1, code_red2;

  always_comb begin
    carrier_cur   = restart_i ? 32'd0 : carrier_acc_q;
    code_cur      = restart_i ? code_start_q : code_acc_q;
    carrier_acc_d = carrier_cur + carrier_step_q;
    code_sum      = SumW'(code_cur) + SumW'(code_step_q[31:bprs_pkg::STEP_ALIGN_SHIFT]);
    // the aligned step is under two periods of the shortest code
    code_red1     = (code_sum >= Limit) ? code_sum - Limit : code_sum;
    code_red2     = (code_red1 >= Limit) ? code_red1 - Limit : code_red1;
    code_acc_d    = code_red2[CodeW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_acc_q <= '0;
      code_acc_q    <= '0;
    end else if (accept) begin
      carrier_acc_q <= carrier_acc_d;
      code_acc_q    <= code_acc_d;
    end
  end

  // stage 1: table phase and chip sign
  logic [COS_TABLE_BITS-1:0] phase1_q;
  logic                      chip_neg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    phase1_q    <= carrier_cur[31 -: COS_TABLE_BITS];
    // chip is negative when prn + 1 + chip index is odd
    chip_neg1_q <= ~(prn_q[0] ^ code_cur[FracW]);
  end

  // quadrant fold onto the quarter-wave table
  logic [1:0]       quad1;
  logic [AddrW-1:0] rom_addr;
  logic             neg1;

  always_comb begin
    quad1    = phase1_q[COS_TABLE_BITS-1 -: 2];
    rom_addr = quad1[0] ? Quarter - AddrW'(phase1_q[FoldW-1:0])
                        : AddrW'(phase1_q[FoldW-1:0]);
    neg1     = chip_neg1_q ^ quad1[1] ^ quad1[0];
  end

  // stage 2: table read
  logic [MagW-1:0] mag2;
  logic            neg2_q;

  bprs_cos_rom #(
    .COS_TABLE_BITS(COS_TABLE_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_cos_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .mag_o (mag2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg2_q <= neg1;
  end

  // sign application
  logic [SAMPLE_BITS-1:0] mag_ext, sample2;

  assign mag_ext = SAMPLE_BITS'(mag2);
  assign sample2 = neg2_q ? (~mag_ext + SAMPLE_BITS'(1)) : mag_ext;

  // result queue
  logic [SAMPLE_BITS-1:0] fifo_data;

  bprs_out_fifo #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(Depth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (v2_q),
    .data_i (sample2),
    .pop_i  (!out_stall_i),
    .valid_o(out_valid_o),
    .data_o (fifo_data),
    .count_o(fifo_count)
  );

  assign i_sample_o = $signed(fifo_data);

endmodule

`default_nettype wire

// ===== dv/bprs_stream_checker.sv =====
`timescale 1ns / 100ps
// bprs_stream_checker: watches the request, result and register ports of the
// bpsk ranging signal generator, predicts every sample and compares it.
// Depends on bprs_pkg for register codes and q30 constants.

module bprs_stream_checker #(
  parameter int unsigned CODE_LENGTH    = bprs_pkg::CODE_LENGTH_DEF,
  parameter int unsigned COS_TABLE_BITS = bprs_pkg::COS_TABLE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS    = bprs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                restart_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [SAMPLE_BITS-1:0]       i_sample_i,
  input  logic                                cfg_we_i,
  input  logic [bprs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bprs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output int                                  pending_o,
  output int                                  mismatches_o
);

  localparam logic [63:0] CODE_LIMIT = 64'(CODE_LENGTH) << bprs_pkg::CODE_FRAC_BITS;
  localparam logic [31:0] TABLE_MASK = ~((32'd1 << (32 - COS_TABLE_BITS)) - 32'd1);

  // shadow registers and phase accumulators
  logic [bprs_pkg::PRN_W-1:0] prn_q;
  logic [31:0]       carrier_step_q;
  logic [31:0]       code_step_q;
  logic [31:0]       code_start_q;
  logic [31:0]       carrier_acc;
  logic [63:0]       code_acc;
  logic [63:0]       chip_num;

  logic signed [SAMPLE_BITS-1:0] sample_q[$];
  logic signed [SAMPLE_BITS-1:0] want;
  int                            errs;

  assign mismatches_o = errs;

  // cosine of a quarter-turn angle (2^30 = quarter turn) in truncated q30
  function automatic logic [63:0] quarter_cos_q30(input logic [63:0] ang);
    logic [63:0] rad;
    logic [63:0] rad_sq;
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] divisor;
    rad    = (ang * bprs_pkg::HALF_PI_Q30) >> 30;
    rad_sq = (rad * rad) >> 30;
    acc    = bprs_pkg::Q30_ONE;
    // horner from the x^12 term down to x^2
    for (int k = 0; k < 6; k++) begin
      case (k)
        0:       divisor = 64'd132;
        1:       divisor = 64'd90;
        2:       divisor = 64'd56;
        3:       divisor = 64'd30;
        4:       divisor = 64'd12;
        default: divisor = 64'd2;
      endcase
      term = ((rad_sq * acc) >> 30) / divisor;
      acc  = (term >= bprs_pkg::Q30_ONE) ? 64'd0 : (bprs_pkg::Q30_ONE - term);
    end
    return acc;
  endfunction

  // signed sample from the carrier phase, inverted when the chip is negative
  function automatic logic signed [SAMPLE_BITS-1:0] predict_sample(
      input logic [31:0] carrier, input logic chip_neg);
    logic [31:0] ph;
    logic [63:0] ang;
    logic [63:0] full_scale;
    logic [63:0] mag;
    logic        neg;
    ph  = carrier & TABLE_MASK;
    ang = 64'(ph[29:0]);
    // odd quadrants mirror the angle
    if (ph[30]) ang = bprs_pkg::Q30_ONE - ang;
    neg        = (ph[31] ^ ph[30]) ^ chip_neg;
    full_scale = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    mag        = (quarter_cos_q30(ang) * full_scale + (64'd1 << 29)) >> 30;
    if (neg) mag = 64'd0 - mag;
    return mag[SAMPLE_BITS-1:0];
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prn_q          = bprs_pkg::PRN_RESET;
      carrier_step_q = bprs_pkg::CARRIER_STEP_RST;
      code_step_q    = bprs_pkg::CODE_STEP_RST;
      code_start_q   = '0;
      carrier_acc    = '0;
      code_acc       = '0;
      sample_q.delete();
      errs           = 0;
      pending_o     <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bprs_pkg::REG_PRN_NUMBER:   prn_q          = cfg_data_i[bprs_pkg::PRN_W-1:0];
          bprs_pkg::REG_CARRIER_STEP: carrier_step_q = cfg_data_i;
          bprs_pkg::REG_CODE_STEP:    code_step_q    = cfg_data_i;
          bprs_pkg::REG_CODE_START:   code_start_q   = cfg_data_i;
          default: ;
        endcase
      end

      // result side first so a sample is never matched against its own request
      if (out_valid_i && !out_stall_i) begin
        if (sample_q.size() == 0) begin
          $error("i_sample: no sample expected, got %0d", i_sample_i);
          errs++;
        end else begin
          want = sample_q.pop_front();
          if (i_sample_i !== want) begin
            $error("i_sample: expected %0d, got %0d", want, i_sample_i);
            errs++;
          end
        end
      end

      // request side: restart, form sample, then advance both phases
      if (in_valid_i && !in_stall_i) begin
        if (restart_i) begin
          carrier_acc = '0;
          code_acc    = 64'(code_start_q) % CODE_LIMIT;
        end
        chip_num = code_acc >> bprs_pkg::CODE_FRAC_BITS;
        // chip is negative when prn + 1 + chip index is odd
        sample_q.push_back(predict_sample(carrier_acc, ~(prn_q[0] ^ chip_num[0])));
        carrier_acc = carrier_acc + carrier_step_q;
        code_acc    = (code_acc + 64'(code_step_q >> bprs_pkg::STEP_ALIGN_SHIFT))
                      % CODE_LIMIT;
      end

      pending_o <= sample_q.size();
    end
  end

endmodule

// ===== dv/tb_bpsk_ranging_signal_generator_top.sv =====
`timescale 1ns / 100ps
// tb_bpsk_ranging_signal_generator_top: clock, reset, requests, register
// settings and result stalls for the generator; checking is left to
// bprs_stream_checker. Depends on bprs_pkg and the generator rtl.

module tb_bpsk_ranging_signal_generator_top;

  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 160;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [31:0] CODE_START_TOP = 32'd4290772991;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid;
  logic                          in_stall;
  logic                          restart;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [bprs_pkg::SAMPLE_BITS_DEF-1:0] i_sample;
  logic                          cfg_we;
  logic [bprs_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [bprs_pkg::CFG_DATA_W-1:0] cfg_data;

  int  pending;
  int  mismatches;
  int  cycles;
  int  n_requests;
  int  n_restarts;
  int  n_settings;
  bit  idle_on;
  int  stall_left;

  bpsk_ranging_signal_generator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .restart_i   (restart),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .i_sample_o  (i_sample),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  bprs_stream_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .restart_i    (restart),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .i_sample_i   (i_sample),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_bpsk_ranging_signal_generator_top: errors");
      $finish;
    end
  end

  // receiver stalls in bursts of random length, only while idle_on is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (!idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // one request, with an optional idle burst ahead of it
  task automatic send_request(input logic rs);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk_i); while (in_stall);
    n_requests++;
    if (rs) n_restarts++;
  endtask

  // stop sending until every expected sample has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all four registers while the block is idle
  task automatic write_settings(input logic [31:0] prn, input logic [31:0] carrier,
                                input logic [31:0] code_step, input logic [31:0] code_start);
    cfg_we   <= 1'b1;
    cfg_idx  <= bprs_pkg::REG_PRN_NUMBER;
    cfg_data <= prn;
    @(posedge clk_i);
    cfg_idx  <= bprs_pkg::REG_CARRIER_STEP;
    cfg_data <= carrier;
    @(posedge clk_i);
    cfg_idx  <= bprs_pkg::REG_CODE_STEP;
    cfg_data <= code_step;
    @(posedge clk_i);
    cfg_idx  <= bprs_pkg::REG_CODE_START;
    cfg_data <= code_start;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    n_settings++;
  endtask

  // word with a bias towards the extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      2:       return 32'($urandom_range(0, 255));
      3:       return 32'($urandom_range(0, 255)) << 22;
      default: return $urandom;
    endcase
  endfunction

  // stimulus
  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    restart    = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = bprs_pkg::REG_PRN_NUMBER;
    cfg_data   = '0;
    n_requests = 0;
    n_restarts = 0;
    n_settings = 0;
    idle_on    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, phases from zero without any restart
    repeat (3) send_request(1'b0);
    drain();

    // quarter-turn carrier steps, largest code step, code start past the end
    write_settings(32'd0, 32'h4000_0000, 32'hffff_ffff, 32'hffff_ffff);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    drain();

    // top prn, carrier step of all ones, frozen code phase at the last chip
    idle_on = 1'b1;
    write_settings(32'd63, 32'hffff_ffff, 32'd0, CODE_START_TOP);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    drain();

    // one table entry per sample, big code step
    write_settings(32'd37, 32'h0040_0000, 32'h8000_0000, 32'd0);
    send_request(1'b1);
    repeat (6) send_request(1'b0);
    drain();

    // random settings, mostly long runs between restarts
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_on = (ph != RAND_PHASES - 1) && ($urandom_range(0, 4) != 0);
      write_settings(32'($urandom_range(0, 63)), pick_word(), pick_word(), pick_word());
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == 0) send_request($urandom_range(0, 3) != 0);
        else        send_request($urandom_range(0, 31) == 0);
      end
      drain();
    end

    $display("run summary: %0d requests, %0d of them restarts, over %0d register settings",
             n_requests, n_restarts, n_settings);
    $display("random idle bursts on both channels, quiet final phase");
    if (mismatches == 0) begin
      $display("tb_bpsk_ranging_signal_generator_top: clean");
    end else begin
      $display("tb_bpsk_ranging_signal_generator_top: errors");
    end
    $finish;
  end

endmodule
